>>> hdl/cc20_pkg.sv
// Shared types, constants and helper functions for the ChaCha20 stream XOR block.
// Used by every module under hdl; depends on nothing else.
package cc20_pkg;

  localparam int WORD_W        = 32;
  localparam int NUM_WORDS     = 16;
  localparam int POS_W         = $clog2(NUM_WORDS);
  localparam int CFG_REGS      = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = $clog2(CFG_REGS);
  localparam int CFG_ADDR_W    = CFG_IDX_W + 3;
  localparam int DOUBLE_ROUNDS = 10;
  localparam int ROUNDS        = 2 * DOUBLE_ROUNDS;
  localparam int ROUND_W       = $clog2(ROUNDS);
  localparam int Q_DEPTH       = 2;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);
  localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

  // Rotation amounts of the four quarter-round steps.
  localparam int ROT_STEP0 = 16;
  localparam int ROT_STEP1 = 12;
  localparam int ROT_STEP2 = 8;
  localparam int ROT_STEP3 = 7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CONSTANT_WORDS_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONSTANT_WORDS_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_0          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_1          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_2          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_3          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_NONCE_LOW   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH          = 3'd7;

  // State word that holds the block counter.
  localparam int COUNTER_WORD = 12;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] words_t;
  typedef logic [CFG_REGS-1:0][CFG_DATA_W-1:0] cfg_regs_t;

  typedef struct packed {
    logic [31:0] data_in;
    logic        restart;
  } in_item_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic        block_end;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_status_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_RUN,
    CORE_ADD
  } core_state_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_BUILD,
    BACK_EMIT
  } back_state_t;

  // Rotate a word left by a constant amount between 1 and 31.
  function automatic word_t rotl(input word_t v, input int n);
    rotl = (v << n) | (v >> (WORD_W - n));
  endfunction

  // State word index for one role (row 0..3) of one quarter-round unit.
  // Column rounds use one column; diagonal rounds shift each row by its number.
  function automatic logic [POS_W-1:0] qr_index(input int unit_sel, input int row,
                                                input logic diag);
    int col;
    col = diag ? ((unit_sel + row) % 4) : unit_sel;
    qr_index = POS_W'(row * 4 + col);
  endfunction

endpackage

>>> hdl/chacha20_stream_xor.sv
// ChaCha20 stream XOR top level: config registers, input queue, keystream core, back end.
// A queued item is taken in BACK_IDLE and its result registered in BACK_EMIT; when a block
// is due, BACK_BUILD waits between them for the core (80 round steps of the quarter-round units + add).
// The back end finishes one word before taking the next; a block is built every 16 words and on restart.
// Reset (rst, synchronous): clears queues, counter, word position and registers to zero.
// Depends on cc20_pkg, cc20_regs, cc20_front, cc20_core and cc20_back.
module chacha20_stream_xor
  import cc20_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              req,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_regs_t    cfg;
  logic         head_valid;
  in_item_t     head;
  logic         deq;
  logic         core_start;
  words_t       core_init;
  core_status_t core_status;
  words_t       keystream;

  // Configuration registers.
  cc20_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input queue.
  cc20_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req        (req),
    .deq        (deq),
    .head_valid (head_valid),
    .head       (head)
  );

  // Keystream block generator.
  cc20_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (core_start),
    .init      (core_init),
    .status    (core_status),
    .keystream (keystream)
  );

  // Sequencer and output register.
  cc20_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_valid  (head_valid),
    .head        (head),
    .deq         (deq),
    .core_start  (core_start),
    .core_init   (core_init),
    .core_status (core_status),
    .keystream   (keystream),
    .pop         (pop),
    .empty       (empty),
    .rsp         (rsp)
  );

endmodule

>>> hdl/cc20_regs.sv
// APB-style configuration register file for the ChaCha20 stream XOR block.
// Depends on cc20_pkg.
module cc20_regs
  import cc20_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_regs_t             cfg
);

  cfg_regs_t            regs;
  logic [CFG_IDX_W-1:0] index;
  logic                 wr_en;

  // Registers sit on 8-byte boundaries; the low address bits are ignored.
  assign index  = paddr[CFG_ADDR_W-1:3];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr_en) begin
      regs[index] <= pwdata;
    end
  end

  assign prdata = regs[index];
  assign cfg    = regs;

endmodule

>>> hdl/cc20_front.sv
// Front end: a short input queue that takes item transfers and holds them for the back end.
// Depends on cc20_pkg.
module cc20_front
  import cc20_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t req,
  input  logic     deq,
  output logic     head_valid,
  output in_item_t head
);

  in_item_t [Q_DEPTH-1:0] entries;
  logic [Q_PTR_W-1:0]     wr_ptr;
  logic [Q_PTR_W-1:0]     rd_ptr;
  logic [Q_CNT_W-1:0]     count;
  logic                   do_push;
  logic                   do_pop;

  assign full       = (count == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push & ~full;
  assign do_pop     = deq & head_valid;

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= req;
    end
  end

endmodule

>>> hdl/cc20_core.sv
// Keystream core: four quarter-round units, one add/xor/rotate step per cycle each.
// Depends on cc20_pkg.
module cc20_core
  import cc20_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  words_t       init,
  output core_status_t status,
  output words_t       keystream
);

  core_state_t        state;
  core_state_t        state_next;
  logic [ROUND_W-1:0] round;
  logic [1:0]         step;
  words_t             init_words;
  words_t             work;
  words_t             work_next;
  logic               last_step;

  assign last_step     = (step == 2'd3) && (round == ROUND_W'(ROUNDS - 1));
  assign status.busy   = (state != CORE_IDLE);
  assign status.done   = (state == CORE_ADD);

  // One step of all four quarter-rounds; even steps update a and d, odd steps c and b.
  always_comb begin
    logic [POS_W-1:0] ia, ib, ic, id;
    word_t            sum;
    work_next = work;
    for (int u = 0; u < 4; u++) begin
      ia = qr_index(u, 0, round[0]);
      ib = qr_index(u, 1, round[0]);
      ic = qr_index(u, 2, round[0]);
      id = qr_index(u, 3, round[0]);
      case (step)
        2'd0: begin
          sum           = work[ia] + work[ib];
          work_next[ia] = sum;
          work_next[id] = rotl(work[id] ^ sum, ROT_STEP0);
        end
        2'd1: begin
          sum           = work[ic] + work[id];
          work_next[ic] = sum;
          work_next[ib] = rotl(work[ib] ^ sum, ROT_STEP1);
        end
        2'd2: begin
          sum           = work[ia] + work[ib];
          work_next[ia] = sum;
          work_next[id] = rotl(work[id] ^ sum, ROT_STEP2);
        end
        default: begin
          sum           = work[ic] + work[id];
          work_next[ic] = sum;
          work_next[ib] = rotl(work[ib] ^ sum, ROT_STEP3);
        end
      endcase
    end
  end

  // Next state of the round sequencer.
  always_comb begin
    state_next = state;
    case (state)
      CORE_IDLE: begin
        if (start) state_next = CORE_RUN;
      end
      CORE_RUN: begin
        if (last_step) state_next = CORE_ADD;
      end
      CORE_ADD: begin
        state_next = CORE_IDLE;
      end
      default: begin
        state_next = CORE_IDLE;
      end
    endcase
  end

  // State register and step counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
      round <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == CORE_IDLE) begin
        round <= '0;
        step  <= '0;
      end else if (state == CORE_RUN) begin
        step <= step + 1'b1;
        if (step == 2'd3) begin
          round <= round + 1'b1;
        end
      end
    end
  end

  // Working state, saved input words and the finished keystream.
  always_ff @(posedge clk) begin
    if (state == CORE_IDLE && start) begin
      init_words <= init;
      work       <= init;
    end else if (state == CORE_RUN) begin
      work <= work_next;
    end
    if (state == CORE_ADD) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        keystream[i] <= work[i] + init_words[i];
      end
    end
  end

endmodule

>>> hdl/cc20_back.sv
// Back end: block counter, word position, core control and the output register.
// Depends on cc20_pkg.
module cc20_back
  import cc20_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_regs_t    cfg,
  input  logic         head_valid,
  input  in_item_t     head,
  output logic         deq,
  output logic         core_start,
  output words_t       core_init,
  input  core_status_t core_status,
  input  words_t       keystream,
  input  logic         pop,
  output logic         empty,
  output out_item_t    rsp
);

  back_state_t      state;
  back_state_t      state_next;
  word_t            cur_data;
  word_t            counter;
  word_t            counter_eff;
  logic [POS_W-1:0] pos;
  logic             ready;
  logic             out_valid;
  logic             need_build;
  logic             load_out;

  // Restart reloads the counter before the block is built for this word.
  assign counter_eff = head.restart ? cfg[REG_COUNTER_NONCE_LOW][WORD_W-1:0] : counter;
  assign need_build  = head.restart | ~ready;
  assign deq         = (state == BACK_IDLE) & head_valid;
  assign core_start  = deq & need_build;
  assign load_out    = (state == BACK_EMIT) & (~out_valid | pop);
  assign empty       = ~out_valid;

  // Initial cipher state from the configuration and the block counter.
  always_comb begin
    for (int i = 0; i < CFG_REGS; i++) begin
      core_init[2*i]   = cfg[i][WORD_W-1:0];
      core_init[2*i+1] = cfg[i][CFG_DATA_W-1:WORD_W];
    end
    core_init[COUNTER_WORD] = counter_eff;
  end

  // Next state of the item sequencer.
  always_comb begin
    state_next = state;
    case (state)
      BACK_IDLE: begin
        if (head_valid) state_next = need_build ? BACK_BUILD : BACK_EMIT;
      end
      BACK_BUILD: begin
        if (core_status.done) state_next = BACK_EMIT;
      end
      BACK_EMIT: begin
        if (load_out) state_next = BACK_IDLE;
      end
      default: begin
        state_next = BACK_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BACK_IDLE;
      counter   <= '0;
      pos       <= '0;
      ready     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (deq) begin
        counter <= counter_eff;
        if (head.restart) begin
          pos   <= '0;
          ready <= 1'b0;
        end
      end
      if (state == BACK_BUILD && core_status.done) begin
        counter <= counter + 1'b1;
        ready   <= 1'b1;
      end
      if (load_out) begin
        pos <= pos + 1'b1;
        if (pos == POS_W'(NUM_WORDS - 1)) begin
          ready <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (deq) begin
      cur_data <= head.data_in;
    end
    if (load_out) begin
      rsp.data_out  <= cur_data ^ keystream[pos];
      rsp.block_end <= (pos == POS_W'(NUM_WORDS - 1));
    end
  end

  // The core reports completion only while a block is awaited.
  a_done_in_build: assert property (@(posedge clk) disable iff (rst)
    core_status.done |-> state == BACK_BUILD)
    else $error("core finished outside of a block build");

  // A word is only emitted with a valid keystream block.
  a_emit_ready: assert property (@(posedge clk) disable iff (rst)
    state == BACK_EMIT |-> ready)
    else $error("word emitted without a keystream block");

  // A started build keeps the core busy in the following cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    core_start |=> state == BACK_BUILD && core_status.busy)
    else $error("core did not start the requested block");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the ChaCha20 stream XOR block: queue-style data ports, APB config.
// Uses cc20_pkg for payload types, register indexes and round constants; needs only the RTL.
`timescale 1ns / 100ps

module testbench;
  import cc20_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_AT        = 400;
  localparam int HOLD_CYCLES    = 500;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 150;
  localparam int DRAIN_CYCLES   = 200;

  // Kinds of configuration setting used between random phases.
  typedef enum int {
    CFG_RANDOM,
    CFG_ZERO,
    CFG_ONES,
    CFG_NEAR_WRAP
  } cfg_kind_t;

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  push    = 1'b0;
  logic                  full;
  in_item_t              req     = '0;
  logic                  empty;
  logic                  pop     = 1'b0;
  out_item_t             rsp;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  chacha20_stream_xor u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .req     (req),
    .empty   (empty),
    .pop     (pop),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be sent, and cipher words predicted but not yet received.
  in_item_t  plain_words_todo[$];
  out_item_t cipher_words_due[$];

  int n_errors     = 0;
  int n_sent       = 0;
  int quiet_cycles = 0;
  int send_gap     = 0;
  int recv_gap     = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  bit offer_busy   = 1'b0;
  bit idle_on      = 1'b1;

  // Cipher predictor state: register copy, current keystream block and position.
  logic [CFG_DATA_W-1:0] cfg_model[CFG_REGS];
  logic [CFG_DATA_W-1:0] cfg_next[CFG_REGS];
  word_t                 ks_words[NUM_WORDS];
  word_t                 mix_w[NUM_WORDS];
  word_t                 blk_ctr  = '0;
  logic [POS_W-1:0]      word_idx = '0;
  logic                  ks_valid = 1'b0;

  // Rotate left: the low word of the doubled value shifted right.
  function automatic word_t rol32(input word_t v, input int n);
    logic [2*WORD_W-1:0] twice;
    twice = {v, v} >> (WORD_W - n);
    return twice[WORD_W-1:0];
  endfunction

  // One quarter-round on the mixing words.
  function automatic void qround(input int a, input int b, input int c, input int d);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rol32(mix_w[d] ^ mix_w[a], ROT_STEP0);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rol32(mix_w[b] ^ mix_w[c], ROT_STEP1);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rol32(mix_w[d] ^ mix_w[a], ROT_STEP2);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rol32(mix_w[b] ^ mix_w[c], ROT_STEP3);
  endfunction

  // Build the next keystream block from the registers and the block counter.
  function automatic void make_keystream();
    word_t init_w[NUM_WORDS];
    int i;
    for (i = 0; i < CFG_REGS; i++) begin
      init_w[2*i]   = cfg_model[i][WORD_W-1:0];
      init_w[2*i+1] = cfg_model[i][CFG_DATA_W-1:WORD_W];
    end
    init_w[COUNTER_WORD] = blk_ctr;
    for (i = 0; i < NUM_WORDS; i++) mix_w[i] = init_w[i];
    for (i = 0; i < DOUBLE_ROUNDS; i++) begin
      qround(0, 4, 8, 12);
      qround(1, 5, 9, 13);
      qround(2, 6, 10, 14);
      qround(3, 7, 11, 15);
      qround(0, 5, 10, 15);
      qround(1, 6, 11, 12);
      qround(2, 7, 8, 13);
      qround(3, 4, 9, 14);
    end
    for (i = 0; i < NUM_WORDS; i++) ks_words[i] = mix_w[i] + init_w[i];
    blk_ctr  = blk_ctr + 1'b1;
    ks_valid = 1'b1;
  endfunction

  // Predict the cipher word for one accepted input word.
  function automatic out_item_t encrypt_word(input in_item_t it);
    out_item_t o;
    if (it.restart) begin
      blk_ctr  = cfg_model[REG_COUNTER_NONCE_LOW][WORD_W-1:0];
      word_idx = '0;
      ks_valid = 1'b0;
    end
    if (!ks_valid) make_keystream();
    o.data_out  = it.data_in ^ ks_words[word_idx];
    o.block_end = (word_idx == POS_W'(NUM_WORDS - 1));
    word_idx = word_idx + 1'b1;
    if (word_idx == '0) ks_valid = 1'b0;
    return o;
  endfunction

  // Gap length for either side: mostly short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Data word with the extremes mixed in.
  function automatic word_t pick_data();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch: %s got %h want %h at %0t", what, got, want, $time);
    n_errors++;
  endtask

  task automatic queue_item(input word_t d, input logic rs);
    in_item_t it;
    it.data_in = d;
    it.restart = rs;
    plain_words_todo.push_back(it);
  endtask

  // Wait until every word is sent and every cipher word has come back.
  task automatic wait_idle();
    while (plain_words_todo.size() != 0 || cipher_words_due.size() != 0) @(negedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_xfer(input logic [CFG_IDX_W-1:0] idx, input logic wr,
                          input logic [CFG_DATA_W-1:0] wdata,
                          output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) cfg_model[idx] = wdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write every register from cfg_next, then read each one back.
  task automatic load_config();
    logic [CFG_DATA_W-1:0] rd;
    int i;
    for (i = 0; i < CFG_REGS; i++) apb_xfer(CFG_IDX_W'(i), 1'b1, cfg_next[i], rd);
    for (i = 0; i < CFG_REGS; i++) begin
      apb_xfer(CFG_IDX_W'(i), 1'b0, '0, rd);
      if (rd !== cfg_model[i]) report_mismatch("register readback", rd, cfg_model[i]);
    end
  endtask

  // Input driver: offer the oldest pending word, with random gaps between transfers.
  always @(negedge clk) begin
    if (!rst && !offer_busy) begin
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (plain_words_todo.size() != 0) begin
        req        <= plain_words_todo[0];
        push       <= 1'b1;
        offer_busy = 1'b1;
        send_gap   = pick_gap();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Input side: on each accepted word, predict its cipher word.
  always @(posedge clk) begin : take_words
    in_item_t it;
    if (!rst && push && !full) begin
      it = plain_words_todo.pop_front();
      cipher_words_due.push_back(encrypt_word(it));
      offer_busy = 1'b0;
      n_sent++;
    end
  end

  // Result receiver: random pop gaps, plus one long hold-off to fill the block.
  always @(negedge clk) begin
    if (!rst) begin
      if (!hold_done && n_sent >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop      <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // Result checker: compare each transfer with the oldest predicted word.
  always @(posedge clk) begin : check_words
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (cipher_words_due.size() == 0) begin
        report_mismatch("result with nothing due", 64'(rsp.data_out), '0);
      end else begin
        want = cipher_words_due.pop_front();
        if (rsp.data_out !== want.data_out)
          report_mismatch("data_out", 64'(rsp.data_out), 64'(want.data_out));
        if (rsp.block_end !== want.block_end)
          report_mismatch("block_end", 64'(rsp.block_end), 64'(want.block_end));
      end
    end
  end

  // Watchdog: end the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Stimulus sequence: directed words, then random phases with varied settings.
  initial begin : run_test
    int        p;
    int        n;
    int        i;
    cfg_kind_t kind;
    logic      rs;

    for (i = 0; i < CFG_REGS; i++) cfg_model[i] = '0;
    for (i = 0; i < NUM_WORDS; i++) begin
      ks_words[i] = '0;
      mix_w[i]    = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // No restart after reset: the first block runs on all-zero registers.
    queue_item('0, 1'b0);
    queue_item('1, 1'b0);
    for (n = 0; n < 12; n++) queue_item($urandom, 1'b0);
    wait_idle();

    // Registers written mid-block: the current block keeps its old keystream.
    cfg_next[REG_CONSTANT_WORDS_LOW]  = {32'h3320646e, 32'h61707865};
    cfg_next[REG_CONSTANT_WORDS_HIGH] = {32'h6b206574, 32'h79622d32};
    cfg_next[REG_KEY_PART_0]          = {32'h07060504, 32'h03020100};
    cfg_next[REG_KEY_PART_1]          = {32'h0f0e0d0c, 32'h0b0a0908};
    cfg_next[REG_KEY_PART_2]          = {32'h17161514, 32'h13121110};
    cfg_next[REG_KEY_PART_3]          = {32'h1f1e1d1c, 32'h1b1a1918};
    cfg_next[REG_COUNTER_NONCE_LOW]   = {32'h09000000, 32'h00000001};
    cfg_next[REG_NONCE_HIGH]          = {32'h00000000, 32'h4a000000};
    load_config();

    // Finish the old block, start one on the new registers, then restart twice,
    // both times in the middle of a block.
    queue_item($urandom, 1'b0);
    queue_item('1, 1'b0);
    queue_item('0, 1'b0);
    queue_item('1, 1'b1);
    for (n = 0; n < 3; n++) queue_item($urandom, 1'b0);
    queue_item('0, 1'b1);
    queue_item($urandom, 1'b0);

    // Random phases; each one rewrites every register while the block is idle.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      case (p)
        1:       kind = CFG_ZERO;
        2:       kind = CFG_ONES;
        3, 6:    kind = CFG_NEAR_WRAP;
        default: kind = CFG_RANDOM;
      endcase
      for (i = 0; i < CFG_REGS; i++) begin
        case (kind)
          CFG_ZERO: cfg_next[i] = '0;
          CFG_ONES: cfg_next[i] = '1;
          default:  cfg_next[i] = {$urandom, $urandom};
        endcase
      end
      if (kind == CFG_NEAR_WRAP)
        cfg_next[REG_COUNTER_NONCE_LOW][WORD_W-1:0] = 32'hFFFFFFFF - $urandom_range(0, 1);
      load_config();

      // One phase runs with no idling on either side.
      idle_on = (p != 4);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 0)
          rs = (kind == CFG_ONES || kind == CFG_NEAR_WRAP) ? 1'b1 : 1'($urandom_range(0, 1));
        else
          rs = ($urandom_range(0, 49) == 0);
        queue_item(pick_data(), rs);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (cipher_words_due.size() != 0)
      report_mismatch("cipher words never received", 64'(cipher_words_due.size()), '0);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/cc20_pkg.sv
hdl/cc20_regs.sv
hdl/cc20_front.sv
hdl/cc20_core.sv
hdl/cc20_back.sv
hdl/chacha20_stream_xor.sv
tb/sv/testbench.sv
